// ----- src/sid_pkg.sv -----
// ----------------------------------------------------------------------------
// sid_pkg
// Shared types and constants for the sorted insert deque and its cell row.
// ----------------------------------------------------------------------------
package sid_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 32;

	typedef enum logic [1:0] {
		OP_APPEND    = 2'd0,
		OP_INSERT    = 2'd1,
		OP_POP_FRONT = 2'd2,
		OP_POP_BACK  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic                    append_en;
		logic                    insert_en;
		logic                    pop_front_en;
		logic                    descending;
		logic [CNT_W-1:0]        count;
		logic signed [KEY_W-1:0] key;
	} cell_cmd_t;

endpackage

// ----- src/sorted_insert_deque.sv -----
// ----------------------------------------------------------------------------
// sorted_insert_deque
// Bounded double-ended buffer of signed keys with append, ordered insert,
// pop front and pop back, built as a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// No request is ever held off: busy never rises, a request may be issued on
// each clock, and its result appears with done in the following cycle. The
// ordered insert completes like any other request because the cells compare in
// parallel; the clock period is set by the move signal rippling through the
// row of cells, one gate per slot. Results cannot be stalled by the receiver.
module sorted_insert_deque (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic                             cfg_wdata,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       operation,
	input  logic signed [sid_pkg::KEY_W-1:0] key_in,
	output logic                             done,
	output logic signed [sid_pkg::KEY_W-1:0] key_out,
	output logic [1:0]                       status,
	output logic [4:0]                       fill_count
);
	import sid_pkg::*;

	logic                    desc_q;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        count_next;
	logic                    done_q;
	logic signed [KEY_W-1:0] key_out_q;
	status_t                 status_q;
	logic [4:0]              fill_q;

	op_t        op;
	logic       is_empty;
	logic       is_full;
	status_t    st_next;
	cell_cmd_t  cmd;

	logic signed [KEY_W-1:0] key_row  [CAPACITY];
	logic signed [KEY_W-1:0] back_c   [CAPACITY+1];
	logic                    shift_c  [CAPACITY+1];
	logic                    move_c   [CAPACITY+1];

	assign op       = op_t'(operation);
	assign is_empty = count_q == '0;
	assign is_full  = count_q == CNT_W'(CAPACITY);
	assign busy     = 1'b0;

	always_comb begin
		st_next    = ST_DONE;
		count_next = count_q;
		unique case (op)
			OP_APPEND, OP_INSERT: begin
				if (is_full) begin
					st_next = ST_FULL;
				end else begin
					count_next = CNT_W'(count_q + 1'b1);
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (is_empty) begin
					st_next = ST_EMPTY;
				end else begin
					count_next = CNT_W'(count_q - 1'b1);
				end
			end
			default: begin
				st_next = ST_DONE;
			end
		endcase
	end

	always_comb begin
		cmd              = '0;
		cmd.append_en    = start && (op == OP_APPEND) && !is_full;
		cmd.insert_en    = start && (op == OP_INSERT) && !is_full;
		cmd.pop_front_en = start && (op == OP_POP_FRONT) && !is_empty;
		cmd.descending   = desc_q;
		cmd.count        = count_q;
		cmd.key          = key_in;
	end

	assign shift_c[0]        = 1'b0;
	assign move_c[CAPACITY]  = 1'b1;
	assign back_c[CAPACITY]  = '0;

	for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
		logic signed [KEY_W-1:0] prev_key;
		logic signed [KEY_W-1:0] next_key;

		if (j == 0) begin : g_first
			assign prev_key = '0;
		end else begin : g_mid
			assign prev_key = key_row[j-1];
		end

		if (j == CAPACITY - 1) begin : g_last
			assign next_key = '0;
		end else begin : g_rest
			assign next_key = key_row[j+1];
		end

		sid_cell u_cell (
			.clk        (clk),
			.idx        (IDX_W'(j)),
			.cmd        (cmd),
			.prev_key   (prev_key),
			.next_key   (next_key),
			.prev_shift (shift_c[j]),
			.move_in    (move_c[j+1]),
			.back_in    (back_c[j+1]),
			.key_q      (key_row[j]),
			.shift      (shift_c[j+1]),
			.move_out   (move_c[j]),
			.back_out   (back_c[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_q  <= 1'b0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			if (cfg_wen) begin
				desc_q <= cfg_wdata;
			end
			done_q <= start;
			if (start) begin
				count_q <= count_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			status_q  <= st_next;
			fill_q    <= 5'(count_next);
			if (op == OP_POP_FRONT && !is_empty) begin
				key_out_q <= key_row[0];
			end else if (op == OP_POP_BACK && !is_empty) begin
				key_out_q <= back_c[0];
			end else begin
				key_out_q <= '0;
			end
		end
	end

	assign done       = done_q;
	assign key_out    = key_out_q;
	assign status     = status_q;
	assign fill_count = fill_q;

endmodule

// ----- src/sid_cell.sv -----
// ----------------------------------------------------------------------------
// sid_cell
// One slot of the key row: compares the broadcast key with its own, and takes
// a key from the slot in front, the slot behind, or the request.
// ----------------------------------------------------------------------------
module sid_cell (
	input  logic                             clk,
	input  logic [sid_pkg::IDX_W-1:0]        idx,
	input  sid_pkg::cell_cmd_t               cmd,
	input  logic signed [sid_pkg::KEY_W-1:0] prev_key,
	input  logic signed [sid_pkg::KEY_W-1:0] next_key,
	input  logic                             prev_shift,
	input  logic                             move_in,
	input  logic signed [sid_pkg::KEY_W-1:0] back_in,
	output logic signed [sid_pkg::KEY_W-1:0] key_q,
	output logic                             shift,
	output logic                             move_out,
	output logic signed [sid_pkg::KEY_W-1:0] back_out
);
	import sid_pkg::*;

	logic [CNT_W-1:0] idx_ext;
	logic             below;
	logic             at_end;
	logic             is_last;
	logic             precedes;

	assign idx_ext  = CNT_W'(idx);
	assign below    = idx_ext < cmd.count;
	assign at_end   = idx_ext == cmd.count;
	assign is_last  = CNT_W'(idx_ext + 1'b1) == cmd.count;
	assign precedes = cmd.descending ? (cmd.key > key_q) : (cmd.key < key_q);

	// A held key moves back when the new key precedes it and every key behind it.
	assign move_out = !below || (precedes && move_in);
	assign shift    = below && move_out;
	assign back_out = is_last ? key_q : back_in;

	always_ff @(posedge clk) begin
		priority if (cmd.pop_front_en) begin
			key_q <= next_key;
		end else if (cmd.insert_en) begin
			if (prev_shift) begin
				key_q <= prev_key;
			end else if (shift || at_end) begin
				key_q <= cmd.key;
			end
		end else if (cmd.append_en && at_end) begin
			key_q <= cmd.key;
		end else begin
			key_q <= key_q;
		end
	end

endmodule
